// File: hdl/jbt_pkg.sv
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants for the JSON byte tokenizer: token kinds and
// the result beat layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

	// token kind codes on the result channel
	typedef enum logic [2:0] {
		K_PUNCT  = 3'd0,
		K_NUMBER = 3'd1,
		K_STRING = 3'd2,
		K_NULL   = 3'd3,
		K_FALSE  = 3'd4,
		K_TRUE   = 3'd5,
		K_ERROR  = 3'd6,
		K_END    = 3'd7
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       token_done;
		logic       last;
	} res_t;

	// most results one input beat can cause
	localparam int unsigned MAX_RES  = 4;
	// result queue slots: one waiting beat plus a full burst
	localparam int unsigned SLOTS    = 5;
	// longest word held for keyword matching
	localparam int unsigned WORD_MAX = 5;

endpackage

`default_nettype wire

// File: hdl/jbt_in_if.sv
// ----------------------------------------------------------------------------
// jbt_in_if
// Text byte channel: valid/ready handshake with at most one text byte per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jbt_in_if;
	logic       valid;
	logic       ready;
	logic       byte_present;
	logic [7:0] text_byte;
	logic       final_req;

	modport source (output valid, output byte_present, output text_byte,
		output final_req, input ready);
	modport sink (input valid, input byte_present, input text_byte,
		input final_req, output ready);
endinterface

`default_nettype wire

// File: hdl/jbt_out_if.sv
// ----------------------------------------------------------------------------
// jbt_out_if
// Token channel: valid/ready handshake with one token result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jbt_out_if
	import jbt_pkg::*;
	;
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] data_byte;
	logic       token_done;
	logic       last;

	modport source (output valid, output kind, output data_byte,
		output token_done, output last, input ready);
	modport sink (input valid, input kind, input data_byte,
		input token_done, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/json_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// json_byte_tokenizer_core
// Streaming JSON lexer: at most one text byte in per beat, a stream of token
// results out, closing pending tokens and adding an end token at end of text.
// ----------------------------------------------------------------------------
// Each input beat is registered, lexed combinationally against the lexer
// state and its results (zero to four) are loaded into a five-entry result
// queue that drains one beat per cycle while the output is ready. A beat
// enters every cycle as long as each beat causes at most one result and the
// output is ready; a beat causing results holds the input until the queue
// has drained to at most one entry, since the output port moves one result
// per cycle only while ready. Beats causing no result pass regardless of the
// queue. A result reaches the output through the input register and the queue.
`timescale 1ns / 1ps
`default_nettype none

module json_byte_tokenizer_core
	import jbt_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	jbt_in_if.sink     in_ch,
	jbt_out_if.source  out_ch
);

	// lexer modes
	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_NUM  = 3'd1,
		M_WORD = 3'd2,
		M_STR  = 3'd3,
		M_ESC  = 3'd4
	} mode_t;

	// what a byte outside any run starts
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
		mode_t      mode;
		logic       dot;
		logic       letter;
	} start_t;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [2:0] WL_MAX = 3'(WORD_MAX);
	localparam logic [2:0] WL_SAT = 3'(WORD_MAX + 1);

	function automatic res_t mk(kind_t k, logic [7:0] d, logic done);
		res_t r;
		r.kind       = k;
		r.data_byte  = d;
		r.token_done = done;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// keyword match on a buffered word
	function automatic kind_t word_kind(logic [WORD_MAX-1:0][7:0] wb, logic [2:0] wl);
		kind_t k;
		k = K_ERROR;
		if (wl == 3'd4 && {wb[0], wb[1], wb[2], wb[3]} == "null")
			k = K_NULL;
		else if (wl == 3'd5 && {wb[0], wb[1], wb[2], wb[3], wb[4]} == "false")
			k = K_FALSE;
		else if (wl == 3'd4 && {wb[0], wb[1], wb[2], wb[3]} == "true")
			k = K_TRUE;
		return k;
	endfunction

	// classify a byte that begins a new token
	function automatic start_t start_tok(logic [7:0] c);
		start_t s;
		s = '0;
		s.mode = M_IDLE;
		if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			s.cnt = 2'd0;
		end else if (c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC
				|| c == CH_COMMA || c == CH_COLON) begin
			s.cnt = 2'd1;
			s.r0  = mk(K_PUNCT, c, 1'b1);
		end else if (c == CH_ZERO) begin
			s.cnt = 2'd2;
			s.r0  = mk(K_NUMBER, c, 1'b0);
			s.r1  = mk(K_NUMBER, 8'h00, 1'b1);
		end else if (c == CH_QUOTE) begin
			s.mode = M_STR;
		end else if ((c >= CH_ONE && c <= CH_NINE) || c == CH_DOT) begin
			s.cnt  = 2'd1;
			s.r0   = mk(K_NUMBER, c, 1'b0);
			s.dot  = (c == CH_DOT);
			s.mode = M_NUM;
		end else if (is_letter(c)) begin
			s.letter = 1'b1;
			s.mode   = M_WORD;
		end else begin
			s.cnt = 2'd1;
			s.r0  = mk(K_ERROR, 8'h00, 1'b1);
		end
		return s;
	endfunction

	// input stage
	logic       valid_s1;
	logic       present_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// lexer state
	mode_t                    mode_q;
	logic                     dot_q;
	logic [WORD_MAX-1:0][7:0] wbuf_q;
	logic [2:0]               wl_q;

	// result queue
	res_t       slot_q [SLOTS];
	logic [2:0] cnt_q;

	// lexer next state and results
	mode_t                    mode_n;
	logic                     dot_n;
	logic [WORD_MAX-1:0][7:0] wbuf_n;
	logic [2:0]               wl_n;
	res_t                     res [MAX_RES];
	logic [2:0]               n_res;
	start_t                   st;
	logic                     do_start;
	logic [7:0]               esc_v;

	logic       consume;
	logic       pop;
	logic       base;
	res_t       slot_n [SLOTS];
	logic [2:0] cnt_n;

	// lex one byte and the end-of-text marker
	always_comb begin
		mode_n   = mode_q;
		dot_n    = dot_q;
		wbuf_n   = wbuf_q;
		wl_n     = wl_q;
		n_res    = 3'd0;
		do_start = 1'b0;
		st       = start_tok(byte_s1);
		esc_v    = byte_s1;
		for (int i = 0; i < MAX_RES; i++)
			res[i] = '0;

		if (byte_s1 == CH_ZERO)
			esc_v = 8'h00;
		else if (byte_s1 == CH_N)
			esc_v = CH_LF;
		else if (byte_s1 == CH_R)
			esc_v = CH_CR;
		else if (byte_s1 == CH_T)
			esc_v = CH_TAB;

		if (present_s1) begin
			unique case (mode_q)
				M_NUM: begin
					if (is_digit(byte_s1) || (byte_s1 == CH_DOT && !dot_q)) begin
						dot_n = dot_q | (byte_s1 == CH_DOT);
						res[n_res[1:0]] = mk(K_NUMBER, byte_s1, 1'b0);
						n_res = n_res + 3'd1;
					end else begin
						res[n_res[1:0]] = mk(K_NUMBER, 8'h00, 1'b1);
						n_res = n_res + 3'd1;
						dot_n = 1'b0;
						do_start = 1'b1;
					end
				end
				M_WORD: begin
					if (is_letter(byte_s1)) begin
						if (wl_q < WL_MAX)
							wbuf_n[wl_q] = byte_s1;
						if (wl_q < WL_SAT)
							wl_n = wl_q + 3'd1;
					end else begin
						res[n_res[1:0]] = mk(word_kind(wbuf_q, wl_q), 8'h00, 1'b1);
						n_res = n_res + 3'd1;
						wl_n = 3'd0;
						do_start = 1'b1;
					end
				end
				M_STR: begin
					if (byte_s1 == CH_QUOTE) begin
						res[n_res[1:0]] = mk(K_STRING, 8'h00, 1'b1);
						n_res = n_res + 3'd1;
						mode_n = M_IDLE;
					end else if (byte_s1 == CH_BSL) begin
						mode_n = M_ESC;
					end else begin
						res[n_res[1:0]] = mk(K_STRING, byte_s1, 1'b0);
						n_res = n_res + 3'd1;
					end
				end
				M_ESC: begin
					res[n_res[1:0]] = mk(K_STRING, esc_v, 1'b0);
					n_res = n_res + 3'd1;
					mode_n = M_STR;
				end
				default: begin
					do_start = 1'b1;
				end
			endcase
		end

		// byte that starts a new token
		if (do_start) begin
			mode_n = st.mode;
			if (st.cnt != 2'd0) begin
				res[n_res[1:0]] = st.r0;
				n_res = n_res + 3'd1;
			end
			if (st.cnt == 2'd2) begin
				res[n_res[1:0]] = st.r1;
				n_res = n_res + 3'd1;
			end
			if (st.mode == M_NUM)
				dot_n = st.dot;
			if (st.letter) begin
				wbuf_n[0] = byte_s1;
				wl_n = 3'd1;
			end
		end

		// end of text closes what is open
		if (final_s1) begin
			unique case (mode_n)
				M_NUM: begin
					res[n_res[1:0]] = mk(K_NUMBER, 8'h00, 1'b1);
					n_res = n_res + 3'd1;
				end
				M_WORD: begin
					res[n_res[1:0]] = mk(word_kind(wbuf_n, wl_n), 8'h00, 1'b1);
					n_res = n_res + 3'd1;
				end
				M_STR, M_ESC: begin
					res[n_res[1:0]] = mk(K_ERROR, 8'h00, 1'b1);
					n_res = n_res + 3'd1;
				end
				default: begin
				end
			endcase
			res[n_res[1:0]] = mk(K_END, 8'h00, 1'b1);
			n_res = n_res + 3'd1;
			mode_n = M_IDLE;
			dot_n  = 1'b0;
			wl_n   = 3'd0;
		end

		// flag the final result of this beat
		for (int i = 0; i < MAX_RES; i++)
			res[i].last = (3'(i) == n_res - 3'd1);
	end

	// handshake
	assign pop      = (cnt_q != 3'd0) && out_ch.ready;
	assign consume  = valid_s1 && (n_res == 3'd0 || cnt_q <= 3'd1);
	assign in_ch.ready = !valid_s1 || consume;
	assign base     = (cnt_q - {2'b00, pop}) != 3'd0;

	// result queue: shift out at the head, load a burst behind what stays
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (pop && i < SLOTS - 1)
				slot_n[i] = slot_q[i+1];
			else
				slot_n[i] = slot_q[i];
		end
		cnt_n = cnt_q - {2'b00, pop};
		if (consume && n_res != 3'd0) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!base && i < MAX_RES && 3'(i) < n_res)
					slot_n[i] = res[i];
				else if (base && i >= 1 && 3'(i - 1) < n_res)
					slot_n[i] = res[i-1];
			end
			cnt_n = {2'b00, base} + n_res;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			present_s1 <= in_ch.byte_present;
			byte_s1    <= in_ch.text_byte;
			final_s1   <= in_ch.final_req;
		end
	end

	// lexer state and queue count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			dot_q  <= 1'b0;
			wl_q   <= 3'd0;
			cnt_q  <= 3'd0;
		end else begin
			cnt_q <= cnt_n;
			if (consume) begin
				mode_q <= mode_n;
				dot_q  <= dot_n;
				wl_q   <= wl_n;
			end
		end
	end

	// word letters and queue payload
	always_ff @(posedge clk) begin
		if (consume)
			wbuf_q <= wbuf_n;
		for (int i = 0; i < SLOTS; i++)
			slot_q[i] <= slot_n[i];
	end

	// output beat from the queue head
	assign out_ch.valid      = (cnt_q != 3'd0);
	assign out_ch.kind       = slot_q[0].kind;
	assign out_ch.data_byte  = slot_q[0].data_byte;
	assign out_ch.token_done = slot_q[0].token_done;
	assign out_ch.last       = slot_q[0].last;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(SLOTS))
		else $error("result queue count out of range");

	// end token is always the closing result of its beat
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == K_END |-> out_ch.last)
		else $error("end token not flagged last");

	// end of text returns the lexer to its reset state
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		consume && final_s1 |=> mode_q == M_IDLE && !dot_q && wl_q == 3'd0)
		else $error("lexer state not cleared after end of text");

endmodule

`default_nettype wire
